@@ sv/ihc_pkg.sv @@
// shared types and constants for the ipv4 header checksum block
package ihc_pkg;

  // width of the link header length register
  localparam int unsigned LinkW = 4;
  // width of the byte position counter within a packet
  localparam int unsigned PosW = 7;

  // ip header byte offsets of the checksum field, read as zero
  localparam logic [PosW-1:0] CsumHiOfs = 7'd10;
  localparam logic [PosW-1:0] CsumLoOfs = 7'd11;

  // checksum reported for a zero length nibble
  localparam logic [15:0] EmptySum = 16'hffff;

  // one input request: a packet byte and its start mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_packet;
  } in_item_t;

  // one result: checksum and header length in bytes
  typedef struct packed {
    logic [15:0] header_checksum;
    logic [5:0]  header_byte_count;
  } out_item_t;

  // result handed from the header logic to the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

@@ sv/ihc_in_stage.sv @@
// input register stage holding one accepted byte request
module ihc_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ihc_pkg::in_item_t in_data,
  output logic              held_valid,
  output ihc_pkg::in_item_t held_data,
  input  logic              held_take
);

  // accept when empty or when the held request moves on this cycle
  assign in_ready = !held_valid || held_take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_data <= in_data;
    end
  end

endmodule

@@ sv/ihc_hdr_sum.sv @@
// header tracking and ones' complement sum, one byte per cycle on each fire
module ihc_hdr_sum (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ihc_pkg::LinkW-1:0]   cfg_link,
  input  logic                        fire,
  input  ihc_pkg::in_item_t           item,
  output ihc_pkg::result_t            result
);

  // state
  logic [ihc_pkg::LinkW-1:0] link_header_bytes;
  logic [ihc_pkg::PosW-1:0]  byte_position, byte_position_next;
  logic [3:0]                header_words, header_words_next;
  logic [15:0]               running_sum, running_sum_next;
  logic [7:0]                held_high_byte, held_high_byte_next;
  logic                      header_active, header_active_next;

  // working values for the current byte
  logic                      act;
  logic [ihc_pkg::PosW-1:0]  pos0, ip, link_ext;
  logic [3:0]                words0, words_eff;
  logic [15:0]               sum0;
  logic [7:0]                held0, byte_z;
  logic                      skip, first, zero_len, is_last;
  logic [16:0]               raw_sum;
  logic [15:0]               folded;

  // start mark restarts the packet state
  always_comb begin
    act      = item.start_of_packet || header_active;
    pos0     = item.start_of_packet ? '0 : byte_position;
    words0   = item.start_of_packet ? '0 : header_words;
    sum0     = item.start_of_packet ? '0 : running_sum;
    held0    = item.start_of_packet ? '0 : held_high_byte;
    link_ext = {{(ihc_pkg::PosW-ihc_pkg::LinkW){1'b0}}, link_header_bytes};
    skip     = pos0 < link_ext;
    ip       = pos0 - link_ext;
    first    = (ip == '0);
    words_eff = first ? item.data_byte[3:0] : words0;
    zero_len = first && (item.data_byte[3:0] == 4'd0);
    byte_z   = (ip == ihc_pkg::CsumHiOfs || ip == ihc_pkg::CsumLoOfs) ? 8'd0 : item.data_byte;
    raw_sum  = {1'b0, sum0} + {1'b0, held0, byte_z};
    folded   = raw_sum[15:0] + {15'd0, raw_sum[16]};
    // last header byte sits at four times the nibble, minus one
    is_last  = ip[0] && (ip == ({1'b0, words_eff, 2'b00} - 7'd1));
  end

  // next state
  always_comb begin
    header_active_next  = header_active;
    byte_position_next  = byte_position;
    header_words_next   = header_words;
    running_sum_next    = running_sum;
    held_high_byte_next = held_high_byte;
    if (act) begin
      header_active_next  = 1'b1;
      byte_position_next  = pos0 + ihc_pkg::PosW'(1);
      header_words_next   = words0;
      running_sum_next    = sum0;
      held_high_byte_next = held0;
      if (!skip) begin
        if (zero_len) begin
          header_active_next = 1'b0;
          byte_position_next = pos0;
        end else begin
          header_words_next = words_eff;
          if (ip[0]) begin
            running_sum_next = folded;
          end else begin
            held_high_byte_next = byte_z;
          end
          if (is_last) begin
            header_active_next = 1'b0;
            byte_position_next = pos0;
          end
        end
      end
    end
  end

  // result for the current byte
  always_comb begin
    result.valid = act && !skip && (zero_len || is_last);
    result.item.header_checksum   = zero_len ? ihc_pkg::EmptySum : ~folded;
    result.item.header_byte_count = zero_len ? 6'd0 : {words_eff, 2'b00};
  end

  // link header length register
  always_ff @(posedge clk) begin
    if (rst) begin
      link_header_bytes <= '0;
    end else if (cfg_we) begin
      link_header_bytes <= cfg_link;
    end
  end

  // packet state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_active  <= 1'b0;
      byte_position  <= '0;
      header_words   <= '0;
      running_sum    <= '0;
      held_high_byte <= '0;
    end else if (fire) begin
      header_active  <= header_active_next;
      byte_position  <= byte_position_next;
      header_words   <= header_words_next;
      running_sum    <= running_sum_next;
      held_high_byte <= held_high_byte_next;
    end
  end

endmodule

@@ sv/ihc_out_stage.sv @@
// result register toward the output channel
module ihc_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  ihc_pkg::result_t   result,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output ihc_pkg::out_item_t out_data
);

  // room for a new result when empty or draining this cycle
  assign free = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= result.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && result.valid) begin
      out_data <= result.item;
    end
  end

endmodule

@@ sv/ipv4_header_checksum.sv @@
// top level of the ipv4 header checksum block
//
// Packet bytes enter one per request on the in channel (valid/ready), each
// with a start-of-packet mark. After skipping the configured link header
// bytes, the low nibble of the first ip byte sets the header length; the
// 16-bit big-endian words of the header are summed with end-around carry,
// the checksum field read as zero. On the last header byte one result with
// the complemented sum and the header byte count goes out on the out channel.
// A zero length nibble gives 0xffff and count 0 right away. A start mark in
// the middle of a header drops it; bytes outside a header give nothing.
// The cfg channel writes the link header length and is always ready.
// Throughput is one byte per cycle while the result register has room; a
// result becomes valid once the byte that completes it has gone from the
// input register through the single 16-bit fold adder into the result register.
// Reset clears all packet state, the link length and both registers. While
// the receiver stalls, one more byte can be held at the input, then in_ready
// drops until the result is taken.
module ipv4_header_checksum (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ihc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ihc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data
);

  logic              held_valid;
  ihc_pkg::in_item_t held_data;
  logic              out_free;
  logic              fire;
  ihc_pkg::result_t  result;

  // configuration is taken at any time
  assign cfg_ready = 1'b1;

  // held byte is processed when the result register has room
  assign fire = held_valid && out_free;

  // input register
  ihc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .held_valid (held_valid),
    .held_data  (held_data),
    .held_take  (fire)
  );

  // header sum logic
  ihc_hdr_sum u_sum (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid),
    .cfg_link (cfg_data),
    .fire     (fire),
    .item     (held_data),
    .result   (result)
  );

  // result register
  ihc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .result    (result),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ sv/ihc_checker.sv @@
// port-level checks for the ipv4 header checksum block
module ihc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ihc_pkg::out_item_t out_data
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no result right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // byte count is a whole number of 32-bit words within range
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.header_byte_count[1:0] == 2'b00
                  && out_data.header_byte_count <= 6'd60)
    else $error("bad header byte count");

  // empty header reports all ones
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.header_byte_count == 6'd0
      |-> out_data.header_checksum == 16'hffff)
    else $error("empty header checksum wrong");

  // input is accepted whenever the output side is free
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind ipv4_header_checksum ihc_checker u_ihc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ verif/tb.sv @@
// testbench for the ipv4 header checksum block: random packets, self-checking
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CycleLimit = 400000;
  // bytes can still sit in the input register with no result due
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned TargetBytes = 950;
  localparam int unsigned MaxReports = 10;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  ihc_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ihc_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [3:0]         cfg_data = '0;

  // stimulus side
  ihc_pkg::in_item_t byte_queue[$];
  int unsigned items_left = 0;
  int unsigned useful_items = 0;
  int unsigned bytes_sent = 0;
  logic [3:0]  link_now = '0;
  bit          no_idle = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          in_acc = 1'b0;
  bit          cfg_acc = 1'b0;

  // checksum predictor state
  logic [3:0]  pred_link = '0;
  logic [6:0]  pred_pos = '0;
  logic [3:0]  pred_words = '0;
  logic [15:0] pred_sum = '0;
  logic [7:0]  pred_hi = '0;
  bit          pred_active = 1'b0;
  ihc_pkg::out_item_t csum_due[$];

  // result bookkeeping
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;

  ipv4_header_checksum u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // 16-bit add with end-around carry
  function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // advance the checksum predictor by one accepted byte
  function automatic void predict_checksum(ihc_pkg::in_item_t it);
    logic [7:0] b;
    logic [6:0] ip;
    ihc_pkg::out_item_t res;
    b = it.data_byte;
    if (it.start_of_packet) begin
      pred_active = 1'b1;
      pred_pos = '0;
      pred_words = '0;
      pred_sum = '0;
      pred_hi = '0;
    end
    if (!pred_active) return;
    // still inside the link header
    if (pred_pos < {3'd0, pred_link}) begin
      pred_pos = pred_pos + 7'd1;
      return;
    end
    ip = pred_pos - {3'd0, pred_link};
    if (ip == 7'd0) begin
      pred_words = b[3:0];
      if (pred_words == 4'd0) begin
        pred_active = 1'b0;
        res.header_checksum = ihc_pkg::EmptySum;
        res.header_byte_count = '0;
        csum_due.push_back(res);
        return;
      end
    end
    // checksum field reads as zero
    if (ip == ihc_pkg::CsumHiOfs || ip == ihc_pkg::CsumLoOfs) b = '0;
    if (!ip[0]) begin
      pred_hi = b;
    end else begin
      pred_sum = ones_add(pred_sum, {pred_hi, b});
      if (ip == {1'b0, pred_words, 2'b00} - 7'd1) begin
        pred_active = 1'b0;
        res.header_checksum = ~pred_sum;
        res.header_byte_count = {pred_words, 2'b00};
        csum_due.push_back(res);
        return;
      end
    end
    pred_pos = pred_pos + 7'd1;
  endfunction

  // compare one result with the oldest expected checksum
  function automatic void check_checksum(ihc_pkg::out_item_t got);
    ihc_pkg::out_item_t exp;
    results_seen++;
    if (csum_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("unexpected result: csum %h count %0d", got.header_checksum,
                 got.header_byte_count);
      return;
    end
    exp = csum_due.pop_front();
    if (got.header_checksum !== exp.header_checksum ||
        got.header_byte_count !== exp.header_byte_count) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("mismatch: expected csum %h count %0d, got csum %h count %0d",
                 exp.header_checksum, exp.header_byte_count,
                 got.header_checksum, got.header_byte_count);
    end
  endfunction

  // sample handshakes at the rising edge
  always @(posedge clk) begin
    in_acc = in_valid && in_ready;
    cfg_acc = cfg_valid && cfg_ready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) pred_link = cfg_data;
      if (in_valid && in_ready) begin
        predict_checksum(in_data);
        items_left--;
        bytes_sent++;
      end
      if (out_valid && out_ready) check_checksum(out_data);
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (byte_queue.size() != 0) begin
        in_data <= byte_queue.pop_front();
        in_valid <= 1'b1;
        gap_left = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic sop, input bit counts);
    ihc_pkg::in_item_t it;
    it.data_byte = b;
    it.start_of_packet = sop;
    byte_queue.push_back(it);
    items_left++;
    if (counts) useful_items++;
  endtask

  // wait until every byte is taken and every checksum has come back
  task automatic wait_idle();
    while (items_left != 0 || csum_due.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_link(input logic [3:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(negedge clk); while (!cfg_acc);
    cfg_valid <= 1'b0;
    link_now = v;
  endtask

  // header length nibble, weighted toward the usual five words
  function automatic logic [3:0] pick_nibble();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 4'd0;
    if (r < 30) return 4'($urandom_range(1, 4));
    if (r < 60) return 4'd5;
    if (r < 85) return 4'($urandom_range(6, 10));
    return 4'($urandom_range(11, 15));
  endfunction

  // one packet: link bytes, header, maybe payload; broken ones stop early
  task automatic send_packet(input bit broken);
    logic [3:0]  nib;
    int unsigned full;
    int unsigned len;
    int unsigned k;
    logic [7:0]  b;
    nib = pick_nibble();
    full = link_now + ((nib == 4'd0) ? 1 : 4 * nib);
    len = (broken && full > 1) ? $urandom_range(1, full - 1) : full;
    for (k = 0; k < len; k++) begin
      b = 8'($urandom_range(0, 255));
      if (k == link_now) b[3:0] = nib;
      send_byte(b, k == 0, 1'b1);
    end
    // trailing bytes are ignored by an idle block
    if (len == full && $urandom_range(0, 99) < 30)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
  endtask

  // stimulus
  initial begin
    logic [3:0]  link_plan[5];
    int unsigned phase;
    int unsigned phase_end;
    link_plan = '{4'd14, 4'd15, 4'd4, 4'd0, 4'd1};
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // directed: idle bytes, empty header, short headers, start mark mid-header
    send_byte(8'hff, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h40, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hf1, 1'b1, 1'b1);
    repeat (3) send_byte(8'hff, 1'b0, 1'b1);
    send_byte(8'h45, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h12, 1'b0, 1'b1);
    send_byte(8'h41, 1'b1, 1'b1);
    send_byte(8'hab, 1'b0, 1'b1);
    send_byte(8'hcd, 1'b0, 1'b1);
    send_byte(8'hef, 1'b0, 1'b1);
    send_byte(8'h02, 1'b1, 1'b1);
    repeat (7) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);

    // random phases, each under its own link length
    phase = 0;
    while (useful_items < TargetBytes) begin
      write_link(phase < 5 ? link_plan[phase] : 4'($urandom_range(0, 15)));
      no_idle = ($urandom_range(0, 3) == 0);
      phase_end = useful_items + 130;
      while (useful_items < phase_end && useful_items < TargetBytes)
        send_packet($urandom_range(0, 99) < 15);
      send_packet(1'b0);
      phase++;
    end
    no_idle = 1'b0;
    wait_idle();

    $display("covered %0d bytes in %0d link settings, %0d checksums compared",
             bytes_sent, phase, results_seen);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ ipv4_header_checksum.f @@
sv/ihc_pkg.sv
sv/ihc_in_stage.sv
sv/ihc_hdr_sum.sv
sv/ihc_out_stage.sv
sv/ipv4_header_checksum.sv
sv/ihc_checker.sv
verif/tb.sv
